// ----- sv/pe_pkg.sv -----
package pe_pkg;

	localparam int PE_NUM_PARTICLES = 32;
	localparam int PE_NUM_SEL       = 5;

	localparam logic [2:0] REG_SPAWN_RATE  = 3'd0;
	localparam logic [2:0] REG_LIFE_SPAN   = 3'd1;
	localparam logic [2:0] REG_SIM_SPEED   = 3'd2;
	localparam logic [2:0] REG_START_POS   = 3'd3;
	localparam logic [2:0] REG_START_VEL   = 3'd4;
	localparam logic [2:0] REG_ACCEL       = 3'd5;
	localparam logic [2:0] REG_COLOUR_PAIR = 3'd6;
	localparam logic [2:0] REG_SIZE_PAIR   = 3'd7;

	localparam logic [2:0] SEL_LAST_AXIS = 3'd2;
	localparam logic [2:0] SEL_SIZE      = 3'd4;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_DT,
		OP_DT,
		OP_MUL_ACC,
		OP_ACC,
		OP_READ,
		OP_AGE,
		OP_MUL_VEL,
		OP_VEL,
		OP_MUL_POS,
		OP_POS,
		OP_MUL_LERP,
		OP_LERP,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] sel;
		logic       last;
	} pe_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_busy;
	} pe_status_t;

	// product / 65536, truncated toward zero
	function automatic logic signed [26:0] trunc16(input logic signed [42:0] p);
		logic signed [42:0] b;
		b = p + (p[42] ? 43'sd65535 : 43'sd0);
		return b[42:16];
	endfunction

	function automatic logic [15:0] sat16(input logic signed [27:0] v);
		if (v > 28'sd32767) return 16'h7fff;
		if (v < -28'sd32768) return 16'h8000;
		return v[15:0];
	endfunction

	// axis 0 is x in the top bits
	function automatic logic [15:0] axis_get(input logic [47:0] v, input logic [2:0] s);
		case (s)
			3'd0:    return v[47:32];
			3'd1:    return v[31:16];
			default: return v[15:0];
		endcase
	endfunction

	function automatic logic [47:0] axis_put(input logic [47:0] v, input logic [2:0] s,
			input logic [15:0] d);
		logic [47:0] r;
		r = v;
		case (s)
			3'd0:    r[47:32] = d;
			3'd1:    r[31:16] = d;
			default: r[15:0] = d;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/pe_ram.sv -----
module pe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/pe_div.sv -----
module pe_div import pe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] num,
	input  logic [15:0] den,
	output logic        done,
	output logic [15:0] quo
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] den_q;
	logic [16:0] r2;
	logic        ge;

	assign r2 = {rem_q, 1'b0};
	assign ge = r2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd16;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) busy_q <= 1'b0;
		end
	end

	// one quotient bit per cycle; the remainder stays below the divisor only if the numerator starts below it
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 16'(r2 - {1'b0, den_q}) : r2[15:0];
			quo_q <= {quo_q[14:0], ge};
		end
	end

	assign done = !busy_q;
	assign quo  = quo_q;

endmodule

// ----- sv/pe_ctrl.sv -----
module pe_ctrl import pe_pkg::*; #(
	parameter int NUM_PARTICLES = PE_NUM_PARTICLES,
	parameter int IDX_W         = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pe_status_t       status,
	output pe_cmd_t          cmd,
	output logic [IDX_W-1:0] idx
);

	typedef enum logic [14:0] {
		S_IDLE     = 15'h0001,
		S_DT_MUL   = 15'h0002,
		S_DT_WR    = 15'h0004,
		S_ACC_MUL  = 15'h0008,
		S_ACC_WR   = 15'h0010,
		S_READ     = 15'h0020,
		S_AGE      = 15'h0040,
		S_VEL_MUL  = 15'h0080,
		S_VEL_WR   = 15'h0100,
		S_POS_MUL  = 15'h0200,
		S_POS_WR   = 15'h0400,
		S_DIV_WAIT = 15'h0800,
		S_LERP_MUL = 15'h1000,
		S_LERP_WR  = 15'h2000,
		S_EMIT     = 15'h4000
	} state_t;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [2:0]       sel_q, sel_d;
	logic             last;

	assign last = (idx_q == IDX_W'(NUM_PARTICLES - 1));

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		sel_d    = sel_q;
		cmd.op   = OP_NONE;
		cmd.sel  = sel_q;
		cmd.last = last;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DT_MUL;
				end
			end
			S_DT_MUL: begin
				cmd.op  = OP_MUL_DT;
				state_d = S_DT_WR;
			end
			S_DT_WR: begin
				cmd.op  = OP_DT;
				state_d = S_ACC_MUL;
			end
			S_ACC_MUL: begin
				cmd.op  = OP_MUL_ACC;
				state_d = S_ACC_WR;
			end
			S_ACC_WR: begin
				cmd.op  = OP_ACC;
				idx_d   = '0;
				state_d = S_READ;
			end
			S_READ: begin
				cmd.op  = OP_READ;
				state_d = S_AGE;
			end
			S_AGE: begin
				cmd.op  = OP_AGE;
				sel_d   = '0;
				state_d = S_VEL_MUL;
			end
			S_VEL_MUL: begin
				cmd.op  = OP_MUL_VEL;
				state_d = S_VEL_WR;
			end
			S_VEL_WR: begin
				cmd.op  = OP_VEL;
				state_d = S_POS_MUL;
			end
			S_POS_MUL: begin
				cmd.op  = OP_MUL_POS;
				state_d = S_POS_WR;
			end
			S_POS_WR: begin
				cmd.op = OP_POS;
				if (sel_q == SEL_LAST_AXIS) begin
					sel_d   = '0;
					state_d = S_DIV_WAIT;
				end else begin
					sel_d   = sel_q + 3'd1;
					state_d = S_VEL_MUL;
				end
			end
			S_DIV_WAIT: begin
				if (status.div_done) state_d = S_LERP_MUL;
			end
			S_LERP_MUL: begin
				cmd.op  = OP_MUL_LERP;
				state_d = S_LERP_WR;
			end
			S_LERP_WR: begin
				cmd.op = OP_LERP;
				if (sel_q == SEL_SIZE) begin
					state_d = S_EMIT;
				end else begin
					sel_d   = sel_q + 3'd1;
					state_d = S_LERP_MUL;
				end
			end
			S_EMIT: begin
				if (!status.out_busy) begin
					cmd.op = OP_EMIT;
					if (last) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = S_READ;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			sel_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			sel_q   <= sel_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign idx      = idx_q;

endmodule

// ----- sv/pe_dp.sv -----
module pe_dp import pe_pkg::*; #(
	parameter int NUM_PARTICLES = PE_NUM_PARTICLES,
	parameter int IDX_W         = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [63:0]      cfg_data,
	input  logic [15:0]      delta_time,
	input  pe_cmd_t          cmd,
	input  logic [IDX_W-1:0] idx,
	output pe_status_t       status,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [103:0]     out_data,
	output logic             out_last
);

	localparam int RAM_W = 112;

	logic [15:0] spawn_rate_q, life_span_q, sim_speed_q;
	logic [47:0] start_pos_q, start_vel_q, accel_q;
	logic [63:0] colour_pair_q;
	logic [31:0] size_pair_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spawn_rate_q  <= 16'd2560;
			life_span_q   <= 16'd256;
			sim_speed_q   <= 16'd256;
			start_pos_q   <= '0;
			start_vel_q   <= '0;
			accel_q       <= '0;
			colour_pair_q <= 64'hffff_ffff_0000_0000;
			size_pair_q   <= 32'h0100_0000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPAWN_RATE:  spawn_rate_q  <= cfg_data[15:0];
				REG_LIFE_SPAN:   life_span_q   <= cfg_data[15:0];
				REG_SIM_SPEED:   sim_speed_q   <= cfg_data[15:0];
				REG_START_POS:   start_pos_q   <= cfg_data[47:0];
				REG_START_VEL:   start_vel_q   <= cfg_data[47:0];
				REG_ACCEL:       accel_q       <= cfg_data[47:0];
				REG_COLOUR_PAIR: colour_pair_q <= cfg_data;
				REG_SIZE_PAIR:   size_pair_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	logic [15:0] delta_q;
	logic [23:0] dt_q;
	logic [15:0] acc_q;
	logic [15:0] spawns_q;
	logic [47:0] pos_q, vel_q;
	logic [15:0] age_q;
	logic        tsat_q;
	logic        rd_valid_q;
	logic [NUM_PARTICLES-1:0] valid_q;
	logic [7:0]  col_q [4];
	logic [15:0] scale_q;
	logic signed [42:0] prod_q;

	// shared multiplier
	logic signed [17:0] mul_a;
	logic signed [24:0] mul_b;
	logic [7:0]         ca, cb;
	logic [15:0]        la, lb;
	logic signed [16:0] ldiff;
	logic [16:0]        t;
	logic [15:0]        quo;
	logic               div_done;

	assign t = tsat_q ? 17'h10000 : {1'b0, quo};

	always_comb begin
		ca = colour_pair_q[63 - 8*cmd.sel -: 8];
		cb = colour_pair_q[31 - 8*cmd.sel -: 8];
		if (cmd.sel == SEL_SIZE) begin
			la = size_pair_q[31:16];
			lb = size_pair_q[15:0];
		end else begin
			la = {8'b0, ca};
			lb = {8'b0, cb};
		end
		ldiff = $signed({1'b0, lb}) - $signed({1'b0, la});
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_DT: begin
				mul_a = $signed({2'b0, delta_q});
				mul_b = $signed({9'b0, sim_speed_q});
			end
			OP_MUL_ACC: begin
				mul_a = $signed({2'b0, spawn_rate_q});
				mul_b = $signed({1'b0, dt_q});
			end
			OP_MUL_VEL: begin
				mul_a = 18'(signed'(axis_get(accel_q, cmd.sel)));
				mul_b = $signed({1'b0, dt_q});
			end
			OP_MUL_POS: begin
				mul_a = 18'(signed'(axis_get(vel_q, cmd.sel)));
				mul_b = $signed({1'b0, dt_q});
			end
			OP_MUL_LERP: begin
				mul_a = 18'(ldiff);
				mul_b = $signed({8'b0, t});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) prod_q <= mul_a * mul_b;

	// memory: position, velocity, age; entries never written read as reset values
	logic             ram_we;
	logic [RAM_W-1:0] ram_wdata, ram_rdata;
	logic [47:0]      rd_pos, rd_vel;
	logic [15:0]      rd_age;
	logic [16:0]      age_sum;
	logic [15:0]      age_new;
	logic             respawn;
	logic [15:0]      age_fin;
	logic [32:0]      acc_sum;
	logic [31:0]      acc_sat;
	logic signed [26:0] q;
	logic signed [27:0] mv_sum;

	assign rd_pos  = rd_valid_q ? ram_rdata[111:64] : '0;
	assign rd_vel  = rd_valid_q ? ram_rdata[63:16] : '0;
	assign rd_age  = rd_valid_q ? ram_rdata[15:0] : 16'hffff;
	assign age_sum = {1'b0, rd_age} + {1'b0, dt_q[23:8]};
	assign age_new = age_sum[16] ? 16'hffff : age_sum[15:0];
	assign respawn = (age_new >= life_span_q) && (spawns_q != '0);
	// the lerp factor follows the age after a respawn
	assign age_fin = respawn ? 16'd0 : age_new;

	assign acc_sum = {17'b0, acc_q} + {1'b0, prod_q[39:8]};
	assign acc_sat = acc_sum[32] ? 32'hffff_ffff : acc_sum[31:0];

	assign q = trunc16(prod_q);

	always_comb begin
		if (cmd.op == OP_VEL)
			mv_sum = 28'(signed'(axis_get(vel_q, cmd.sel))) + 28'(q);
		else
			mv_sum = 28'(signed'(axis_get(pos_q, cmd.sel))) + 28'(q);
	end

	assign ram_we    = (cmd.op == OP_EMIT);
	assign ram_wdata = {pos_q, vel_q, age_q};

	pe_ram #(.WIDTH(RAM_W), .DEPTH(NUM_PARTICLES), .AW(IDX_W)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx),
		.wdata (ram_wdata),
		.raddr (idx),
		.rdata (ram_rdata)
	);

	pe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_AGE),
		.num    (age_fin),
		.den    (life_span_q),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			acc_q      <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_ACC) acc_q <= acc_sat[15:0];
			if (cmd.op == OP_READ) rd_valid_q <= valid_q[idx];
			if (cmd.op == OP_EMIT) valid_q[idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: delta_q <= delta_time;
			OP_DT:   dt_q <= prod_q[31:8];
			OP_ACC:  spawns_q <= acc_sat[31:16];
			OP_AGE: begin
				tsat_q <= age_fin >= life_span_q;
				if (respawn) begin
					spawns_q <= spawns_q - 16'd1;
					age_q    <= '0;
					pos_q    <= start_pos_q;
					vel_q    <= start_vel_q;
				end else begin
					age_q <= age_new;
					pos_q <= rd_pos;
					vel_q <= rd_vel;
				end
			end
			OP_VEL:  vel_q <= axis_put(vel_q, cmd.sel, sat16(mv_sum));
			OP_POS:  pos_q <= axis_put(pos_q, cmd.sel, sat16(mv_sum));
			OP_LERP: begin
				if (cmd.sel == SEL_SIZE) scale_q <= la + q[15:0];
				else col_q[cmd.sel[1:0]] <= ca + q[7:0];
			end
			default: ;
		endcase
	end

	// output register, fields from the lowest bit up
	logic [4:0] idx5;
	assign idx5 = 5'(idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.op == OP_EMIT) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			out_data <= {3'b0, scale_q, col_q[3], col_q[2], col_q[1], col_q[0],
				pos_q[15:0], pos_q[31:16], pos_q[47:32], idx5};
			out_last <= cmd.last;
		end
	end

	assign status.div_done = div_done;
	assign status.out_busy = out_valid && !out_ready;

endmodule

// ----- sv/particle_emitter_update.sv -----
// particle emitter update: one tick beat in, one result beat per particle out
// particles are processed one after another; a new tick beat is taken only after the last
// particle's result is issued, and the pace per particle is set by the shared multiplier
// (11 products per particle), the bit-serial age divider and output back-pressure
// arst_n clears control, registers to their defaults and the per-entry valid bits;
// particles read as expired at the origin until first written
module particle_emitter_update import pe_pkg::*; #(
	parameter int NUM_PARTICLES = PE_NUM_PARTICLES,
	parameter int IDX_W         = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [15:0]  s_axis_tdata,   // delta_time
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// particle_index, pos_x, pos_y, pos_z, colour_r, colour_g, colour_b, colour_a,
	// uniform_scale, zero pad
	output logic [103:0] m_axis_tdata,
	output logic         m_axis_tlast    // last_particle
);

	pe_cmd_t          cmd;
	pe_status_t       status;
	logic [IDX_W-1:0] idx;

	pe_ctrl #(.NUM_PARTICLES(NUM_PARTICLES), .IDX_W(IDX_W)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd),
		.idx      (idx)
	);

	pe_dp #(.NUM_PARTICLES(NUM_PARTICLES), .IDX_W(IDX_W)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.delta_time (s_axis_tdata),
		.cmd        (cmd),
		.idx        (idx),
		.status     (status),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_last   (m_axis_tlast)
	);

endmodule

// ----- verif/particle_checker.sv -----
`timescale 1ns / 1ps
module particle_checker import pe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [15:0]  s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [103:0] m_axis_tdata,
	input  logic         m_axis_tlast,
	output int           fail_count,
	output int           pending_results
);

	typedef struct packed {
		logic [4:0]  idx;
		logic [15:0] px, py, pz;
		logic [7:0]  r, g, b, a;
		logic [15:0] scale;
		logic        last;
	} particle_out_t;

	logic [15:0] spawn_rate, life_span, sim_speed;
	logic [47:0] start_pos, start_vel, accel;
	logic [63:0] colour_pair;
	logic [31:0] size_pair;
	logic [47:0] ppos [PE_NUM_PARTICLES];
	logic [47:0] pvel [PE_NUM_PARTICLES];
	logic [15:0] page [PE_NUM_PARTICLES];
	logic [31:0] spawn_acc;
	particle_out_t expected_particles[$];

	assign pending_results = expected_particles.size();

	function automatic longint sext16(input logic [15:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint clamp16(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint blend(input longint a, input longint b, input longint t);
		return a + ((b - a) * t) / 65536;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic advance_tick(input logic [15:0] delta);
		longint dt, acc, spawns, dage, age, t, v, p, sh;
		particle_out_t o;
		logic [47:0] pos, vel;
		dt = (longint'(delta) * longint'(sim_speed)) >>> 8;
		acc = longint'(spawn_acc) + ((longint'(spawn_rate) * dt) >>> 8);
		if (acc > 64'hFFFFFFFF) acc = 64'hFFFFFFFF;
		spawns = acc >>> 16;
		spawn_acc = 32'(acc & 16'hFFFF);
		dage = dt >>> 8;
		for (int i = 0; i < PE_NUM_PARTICLES; i++) begin
			age = longint'(page[i]) + dage;
			if (age > 65535) age = 65535;
			if (age >= life_span && spawns > 0) begin
				spawns--;
				age = 0;
				ppos[i] = start_pos;
				pvel[i] = start_vel;
			end
			page[i] = 16'(age);
			pos = ppos[i];
			vel = pvel[i];
			for (int ax = 0; ax < 3; ax++) begin
				sh = 32 - 16 * ax;
				v = clamp16(sext16(vel[sh +: 16]) + (sext16(accel[sh +: 16]) * dt) / 65536);
				p = clamp16(sext16(pos[sh +: 16]) + (v * dt) / 65536);
				vel[sh +: 16] = 16'(v);
				pos[sh +: 16] = 16'(p);
			end
			pvel[i] = vel;
			ppos[i] = pos;
			if (life_span == 0) t = 65536;
			else begin
				t = (age << 16) / longint'(life_span);
				if (t > 65536) t = 65536;
			end
			o.idx = 5'(i);
			o.px = pos[47:32];
			o.py = pos[31:16];
			o.pz = pos[15:0];
			o.r = 8'(blend(colour_pair[63:56], colour_pair[31:24], t));
			o.g = 8'(blend(colour_pair[55:48], colour_pair[23:16], t));
			o.b = 8'(blend(colour_pair[47:40], colour_pair[15:8], t));
			o.a = 8'(blend(colour_pair[39:32], colour_pair[7:0], t));
			o.scale = 16'(blend(size_pair[31:16], size_pair[15:0], t));
			o.last = (i == PE_NUM_PARTICLES - 1);
			expected_particles.push_back(o);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		particle_out_t w, g;
		if (!arst_n) begin
			spawn_rate <= 16'h0A00;
			life_span <= 16'h0100;
			sim_speed <= 16'h0100;
			start_pos = '0;
			start_vel = '0;
			accel = '0;
			colour_pair = 64'hFFFFFFFF00000000;
			size_pair = 32'h01000000;
			for (int i = 0; i < PE_NUM_PARTICLES; i++) begin
				ppos[i] = '0;
				pvel[i] = '0;
				page[i] = 16'hFFFF;
			end
			spawn_acc = '0;
			fail_count = 0;
			expected_particles.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				g.idx = m_axis_tdata[4:0];
				g.px = m_axis_tdata[20:5];
				g.py = m_axis_tdata[36:21];
				g.pz = m_axis_tdata[52:37];
				g.r = m_axis_tdata[60:53];
				g.g = m_axis_tdata[68:61];
				g.b = m_axis_tdata[76:69];
				g.a = m_axis_tdata[84:77];
				g.scale = m_axis_tdata[100:85];
				g.last = m_axis_tlast;
				if (expected_particles.size() == 0) report_mismatch("unexpected beat", g.idx, 0);
				else begin
					w = expected_particles.pop_front();
					if (g.idx !== w.idx) report_mismatch("particle_index", g.idx, w.idx);
					if (g.px !== w.px) report_mismatch("pos_x", g.px, w.px);
					if (g.py !== w.py) report_mismatch("pos_y", g.py, w.py);
					if (g.pz !== w.pz) report_mismatch("pos_z", g.pz, w.pz);
					if (g.r !== w.r) report_mismatch("colour_r", g.r, w.r);
					if (g.g !== w.g) report_mismatch("colour_g", g.g, w.g);
					if (g.b !== w.b) report_mismatch("colour_b", g.b, w.b);
					if (g.a !== w.a) report_mismatch("colour_a", g.a, w.a);
					if (g.scale !== w.scale) report_mismatch("uniform_scale", g.scale, w.scale);
					if (g.last !== w.last) report_mismatch("last_particle", g.last, w.last);
				end
			end
			if (s_axis_tvalid && s_axis_tready) advance_tick(s_axis_tdata);
			if (cfg_we) begin
				case (cfg_index)
					REG_SPAWN_RATE:  spawn_rate <= cfg_data[15:0];
					REG_LIFE_SPAN:   life_span <= cfg_data[15:0];
					REG_SIM_SPEED:   sim_speed <= cfg_data[15:0];
					REG_START_POS:   start_pos = cfg_data[47:0];
					REG_START_VEL:   start_vel = cfg_data[47:0];
					REG_ACCEL:       accel = cfg_data[47:0];
					REG_COLOUR_PAIR: colour_pair = cfg_data;
					REG_SIZE_PAIR:   size_pair = cfg_data[31:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench import pe_pkg::*;;

	localparam int WATCHDOG_LIMIT = 40000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [63:0]  cfg_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [15:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;
	logic         m_axis_tlast;
	int           fail_count, pending_results;
	int           sender_idle_pct = 0, receiver_idle_pct = 0;
	int           hold_off_cycles = 0;
	int           ticks_sent = 0, quiet_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	particle_emitter_update DUT (.*);

	particle_checker checker_i (.*);

	// receiver: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= arst_n && ($urandom_range(99) >= receiver_idle_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("FAIL particle_emitter_update");
			$finish;
		end
	end

	// valid stays up after a beat until the next idle cycle or the drain
	task automatic send_tick(input logic [15:0] delta);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= delta;
		do @(posedge clk); while (!s_axis_tready);
		ticks_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] random_delta();
		case ($urandom_range(3))
			0: return 16'($urandom_range(1023));
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_setting();
		write_reg(REG_SPAWN_RATE, 64'($urandom_range(3) == 0 ? 16'hFFFF : $urandom_range(8191)));
		write_reg(REG_LIFE_SPAN, 64'($urandom_range(7) == 0 ? 0 : $urandom_range(65535)));
		write_reg(REG_SIM_SPEED, 64'($urandom_range(3) == 0 ? 16'hFFFF : $urandom_range(1023)));
		write_reg(REG_START_POS, {$urandom, $urandom});
		write_reg(REG_START_VEL, {$urandom, $urandom});
		write_reg(REG_ACCEL, {$urandom, $urandom});
		write_reg(REG_COLOUR_PAIR, {$urandom, $urandom});
		write_reg(REG_SIZE_PAIR, 64'($urandom));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// defaults first: zero, tiny and full-scale ticks
		send_tick(16'h0000);
		send_tick(16'h0001);
		send_tick(16'hFFFF);
		send_tick(16'h8000);
		drain();
		// extremes of every register, including a zero lifetime
		write_reg(REG_SPAWN_RATE, 64'hFFFF);
		write_reg(REG_LIFE_SPAN, 64'h0000);
		write_reg(REG_SIM_SPEED, 64'hFFFF);
		write_reg(REG_START_POS, 64'h7FFF_8000_0001);
		write_reg(REG_START_VEL, 64'h7FFF_8000_FFFF);
		write_reg(REG_ACCEL, 64'h7FFF_8000_7FFF);
		write_reg(REG_COLOUR_PAIR, 64'h00FF_00FF_FF00_FF00);
		write_reg(REG_SIZE_PAIR, 64'hFFFF_0000);
		repeat (4) send_tick(16'hFFFF);
		send_tick(16'h0000);
		drain();
		write_reg(REG_LIFE_SPAN, 64'hFFFF);
		write_reg(REG_SPAWN_RATE, 64'h0000);
		write_reg(REG_SIM_SPEED, 64'h0000);
		send_tick(16'hFFFF);
		drain();
		write_reg(REG_SIM_SPEED, 64'h0100);
		repeat (3) send_tick(16'hAAAA);
		send_tick(16'h5555);
		drain();
		// spawns run out partway through the walk
		write_reg(REG_LIFE_SPAN, 64'h0001);
		write_reg(REG_SPAWN_RATE, 64'h0400);
		write_reg(REG_START_VEL, 64'h0100_FF00_0080);
		write_reg(REG_ACCEL, 64'h8000_7FFF_0000);
		write_reg(REG_COLOUR_PAIR, 64'h1234_5678_9ABC_DEF0);
		repeat (5) send_tick(16'($urandom));
		drain();
		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 75 : 0;
			receiver_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 18 : 0;
			for (int k = 0; k < 4; k++) begin
				random_setting();
				if (phase == 2 && k == 0) hold_off_cycles = 3000;
				repeat (25) send_tick(random_delta());
				drain();
			end
		end
		$display("covered %0d ticks over directed extremes and 12 random register settings,",
			ticks_sent);
		$display("with input and output stalls and a long output hold-off");
		if (fail_count == 0)
			$display("PASS particle_emitter_update");
		else
			$display("FAIL particle_emitter_update");
		$finish;
	end

endmodule

// ----- particle_emitter_update.f -----
sv/pe_pkg.sv
sv/pe_ram.sv
sv/pe_div.sv
sv/pe_ctrl.sv
sv/pe_dp.sv
sv/particle_emitter_update.sv
verif/particle_checker.sv
verif/testbench.sv
